>>> rtl/core/bsesc_pkg.sv
// ----------------------------------------------------------------------------
// bsesc_pkg
// Shared types, constants and helpers for the backslash escape encoder.
// ----------------------------------------------------------------------------
package bsesc_pkg;

  localparam int CHAR_BITS = 8;

  // Command queue between the classifier and the expander
  localparam int CMDQ_DEPTH = 2;
  localparam int QPTR_W     = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QCNT_W     = $clog2(CMDQ_DEPTH + 1);

  // Longest expansion is a backslash, an x and eight hex digits
  localparam int MAX_RUN = 10;
  localparam int POS_W   = $clog2(MAX_RUN);

  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_QUOTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_QUOTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_NP    = 2'd2;

  localparam logic [CHAR_BITS-1:0] CH_NUL    = CHAR_BITS'(0);
  localparam logic [CHAR_BITS-1:0] CH_BEL    = CHAR_BITS'(7);
  localparam logic [CHAR_BITS-1:0] CH_BS     = CHAR_BITS'(8);
  localparam logic [CHAR_BITS-1:0] CH_LF     = CHAR_BITS'(10);
  localparam logic [CHAR_BITS-1:0] CH_VT     = CHAR_BITS'(11);
  localparam logic [CHAR_BITS-1:0] CH_FF     = CHAR_BITS'(12);
  localparam logic [CHAR_BITS-1:0] CH_CR     = CHAR_BITS'(13);
  localparam logic [CHAR_BITS-1:0] CH_SPACE  = CHAR_BITS'(32);
  localparam logic [CHAR_BITS-1:0] CH_DQUOTE = CHAR_BITS'(34);
  localparam logic [CHAR_BITS-1:0] CH_SQUOTE = CHAR_BITS'(39);
  localparam logic [CHAR_BITS-1:0] CH_ZERO   = CHAR_BITS'(48);
  localparam logic [CHAR_BITS-1:0] CH_NINE   = CHAR_BITS'(57);
  localparam logic [CHAR_BITS-1:0] CH_UA     = CHAR_BITS'(65);
  localparam logic [CHAR_BITS-1:0] CH_UF     = CHAR_BITS'(70);
  localparam logic [CHAR_BITS-1:0] CH_BSLASH = CHAR_BITS'(92);
  localparam logic [CHAR_BITS-1:0] CH_LA     = CHAR_BITS'(97);
  localparam logic [CHAR_BITS-1:0] CH_LB     = CHAR_BITS'(98);
  localparam logic [CHAR_BITS-1:0] CH_LF_A   = CHAR_BITS'(102);
  localparam logic [CHAR_BITS-1:0] CH_LN     = CHAR_BITS'(110);
  localparam logic [CHAR_BITS-1:0] CH_LR     = CHAR_BITS'(114);
  localparam logic [CHAR_BITS-1:0] CH_LV     = CHAR_BITS'(118);
  localparam logic [CHAR_BITS-1:0] CH_LX     = CHAR_BITS'(120);
  localparam logic [CHAR_BITS-1:0] CH_TILDE  = CHAR_BITS'(126);

  typedef struct packed {
    logic [1:0]           op;
    logic [CHAR_BITS-1:0] in_char;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] out_char;
    logic                 last_of_run;
  } out_item_t;

  typedef struct packed {
    logic double_quote_mode;
    logic add_quotes;
    logic escape_non_printable;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_LIT,   // one character as is
    CMD_PAIR,  // backslash and one character
    CMD_HEX    // backslash, x and ndig hex digits
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [CHAR_BITS-1:0] value;
    logic [3:0]           ndig;
  } cmd_t;

  function automatic logic [CHAR_BITS-1:0] hex_char(logic [3:0] n);
    logic [7:0] code;
    if (n < 4'd10) begin
      code = 8'd48 + 8'(n);
    end else begin
      code = 8'd87 + 8'(n);
    end
    return CHAR_BITS'(code);
  endfunction

endpackage

>>> rtl/core/bsesc_front.sv
// ----------------------------------------------------------------------------
// bsesc_front
// Accepts input transactions, classifies each character and queues a command.
// ----------------------------------------------------------------------------
module bsesc_front
  import bsesc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic                 hex_flag_r;
  logic                 hex_flag_nxt;
  logic                 accept;
  logic                 has_cmd;
  logic [CHAR_BITS-1:0] c;
  logic [CHAR_BITS-1:0] esc;
  logic [31:0]          c32;
  logic                 non_printable;
  logic                 is_hex_digit;
  logic [3:0]           ndig;
  cmd_t                 cmd;

  function automatic logic [CHAR_BITS-1:0] simple_escape(logic [CHAR_BITS-1:0] ch,
                                                         logic dq);
    logic [CHAR_BITS-1:0] r;
    r = CH_NUL;
    if (ch == CH_BSLASH) r = CH_BSLASH;
    else if (ch == CH_DQUOTE && dq) r = CH_DQUOTE;
    else if (ch == CH_SQUOTE && !dq) r = CH_SQUOTE;
    else if (ch == CH_NUL) r = CH_ZERO;
    else if (ch == CH_LF) r = CH_LN;
    else if (ch == CH_CR) r = CH_LR;
    else if (ch == CH_BS) r = CH_LB;
    else if (ch == CH_FF) r = CH_LF_A;
    else if (ch == CH_BEL) r = CH_LA;
    else if (ch == CH_VT) r = CH_LV;
    return r;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    c             = in_data.in_char;
    c32           = 32'(c);
    esc           = simple_escape(c, cfg.double_quote_mode);
    non_printable = cfg.escape_non_printable && (c < CH_SPACE || c > CH_TILDE);
    is_hex_digit  = (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF_A) ||
                    (c >= CH_UA && c <= CH_UF);
    // Wide codes pick a longer escape when the character width allows it
    if (CHAR_BITS > 16 && c32[31:16] != 16'd0) begin
      ndig = 4'd8;
    end else if (CHAR_BITS > 8 && c32[31:8] != 24'd0) begin
      ndig = 4'd4;
    end else begin
      ndig = 4'd2;
    end

    cmd          = '{kind: CMD_LIT, value: c, ndig: 4'd2};
    has_cmd      = 1'b0;
    hex_flag_nxt = hex_flag_r;

    unique case (in_data.op) inside
      OP_START, OP_END: begin
        hex_flag_nxt = 1'b0;
        has_cmd      = cfg.add_quotes;
        cmd.value    = cfg.double_quote_mode ? CH_DQUOTE : CH_SQUOTE;
      end
      OP_CHAR: begin
        has_cmd = 1'b1;
        if (esc != CH_NUL) begin
          cmd.kind     = CMD_PAIR;
          cmd.value    = esc;
          hex_flag_nxt = 1'b0;
        end else if (non_printable) begin
          cmd.kind     = CMD_HEX;
          cmd.ndig     = ndig;
          hex_flag_nxt = 1'b1;
        end else if (hex_flag_r && is_hex_digit) begin
          // keep the digit from merging with the escape before it
          cmd.kind = CMD_HEX;
        end else begin
          hex_flag_nxt = 1'b0;
        end
      end
      default: begin
        has_cmd = 1'b0;
      end
    endcase
  end

  assign q_push = accept && has_cmd;
  assign q_cmd  = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_flag_r <= 1'b0;
    end else if (accept) begin
      hex_flag_r <= hex_flag_nxt;
    end
  end

endmodule

>>> rtl/core/bsesc_cmdq.sv
// ----------------------------------------------------------------------------
// bsesc_cmdq
// Short command queue that decouples the classifier from the expander.
// ----------------------------------------------------------------------------
module bsesc_cmdq
  import bsesc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t              entries_r [CMDQ_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign full       = (count_r == QCNT_W'(CMDQ_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/core/bsesc_back.sv
// ----------------------------------------------------------------------------
// bsesc_back
// Expands the head command into output characters, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module bsesc_back
  import bsesc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  cmd_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [POS_W-1:0]     pos_r;
  logic [POS_W-1:0]     pos_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  out_item_t            out_data_r;
  logic [POS_W-1:0]     run_len;
  logic [CHAR_BITS-1:0] ch;
  logic                 is_last;
  logic                 load;
  logic [3:0]           dig_sel;
  logic [31:0]          val32;

  always_comb begin
    val32   = 32'(head.value);
    // digits go out most significant first
    dig_sel = head.ndig + 4'd1 - 4'(pos_r);
    run_len = POS_W'(1);
    ch      = head.value;
    unique case (head.kind)
      CMD_LIT: begin
        run_len = POS_W'(1);
        ch      = head.value;
      end
      CMD_PAIR: begin
        run_len = POS_W'(2);
        ch      = (pos_r == '0) ? CH_BSLASH : head.value;
      end
      CMD_HEX: begin
        run_len = POS_W'(head.ndig) + POS_W'(2);
        if (pos_r == '0) begin
          ch = CH_BSLASH;
        end else if (pos_r == POS_W'(1)) begin
          ch = CH_LX;
        end else begin
          ch = hex_char(val32[dig_sel[2:0]*4 +: 4]);
        end
      end
      default: begin
        run_len = POS_W'(1);
        ch      = head.value;
      end
    endcase
    is_last = (pos_r == run_len - POS_W'(1));
  end

  assign load = head_valid && (!out_valid_r || !out_stall);
  assign pop  = load && is_last;

  always_comb begin
    pos_nxt = pos_r;
    if (load) begin
      pos_nxt = is_last ? '0 : pos_r + 1'b1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the payload while the receiver stalls
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= '{out_char: ch, last_of_run: is_last};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/backslash_escape_encoder.sv
// ----------------------------------------------------------------------------
// backslash_escape_encoder
// Streams a string and emits its backslash-escaped form.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): one transaction per character,
// string start or string end. Output channel (out_valid/out_stall/out_data):
// one transaction per emitted character, last_of_run marks the final one of
// the run caused by an input transaction.
// Configuration: cfg_we writes bit 0 of cfg_wdata into the register chosen
// by cfg_index (quote mode, add quotes, escape non-printable); write only
// while the block is idle.
// Path: with an empty queue the first output character of an item is written
// into a queue entry when the item is accepted and then into the output
// register, where it becomes valid.
// Throughput: the expander gives one output character per cycle unless the
// output stalls; a plain character yields one, a simple escape two and a
// hex escape 4, 6 or 10. The two-entry command queue lets the classifier
// keep accepting while a run expands; in_stall rises once the queue is full.
// Reset: clears the queue, the output valid and the hex-escape flag, and
// loads the configuration defaults (double quotes, no quotes, no hex).
// Output stall: the output register holds its transaction; the expander
// and then the queue back up until input is stalled.
// ----------------------------------------------------------------------------
module backslash_escape_encoder
  import bsesc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata
);

  cfg_t cfg_r;
  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{double_quote_mode: 1'b1, add_quotes: 1'b0, escape_non_printable: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DOUBLE_QUOTE: cfg_r.double_quote_mode    <= cfg_wdata;
        REG_ADD_QUOTES:   cfg_r.add_quotes           <= cfg_wdata;
        REG_ESCAPE_NP:    cfg_r.escape_non_printable <= cfg_wdata;
        default:          cfg_r                      <= cfg_r;
      endcase
    end
  end

  bsesc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  bsesc_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  bsesc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> rtl/core/bsesc_checker.sv
// ----------------------------------------------------------------------------
// bsesc_checker
// Port-level checks for the backslash escape encoder.
// ----------------------------------------------------------------------------
module bsesc_checker
  import bsesc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output transaction changed under stall");

  // a run that is not finished continues in the next cycle
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_of_run |=> out_valid)
    else $error("gap inside an escape run");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind backslash_escape_encoder bsesc_checker u_bsesc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> bench/backslash_escape_encoder_tb.sv
// ----------------------------------------------------------------------------
// backslash_escape_encoder_tb
// Self-checking bench for the backslash escape encoder.
// ----------------------------------------------------------------------------
// Input items are driven at the falling edge. Every accepted item is run
// through a local escape predictor, and the characters it predicts are queued.
// Each output transaction is checked against the head of that queue.
// The opening table has directed rows: extremes, all simple escapes, quote
// modes, hex escapes and the hex-digit-after-escape rule. Rows whose output
// is obvious carry their text inline. The random phases that follow go
// through all eight register settings. Sender and receiver idle at random,
// and one long receiver hold-off lets the block fill up and stall its input.
// ----------------------------------------------------------------------------
module backslash_escape_encoder_tb;
  import bsesc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CHAR_BITS-1:0] CH_TAB = CHAR_BITS'(9);

  localparam int PHASE_ITEMS   = 56;
  localparam int MAX_WAIT      = 18;
  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_LIMIT   = 5000;
  localparam longint TIMEOUT   = 64'd10_000_000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic                 val;
    in_item_t             item;
    logic                 fixed;
    int                   nfixed;
    logic [31:0]          text;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic                 cfg_wdata = 1'b0;

  // predictor copy of the registers and the escape state
  logic quote_dq = 1'b1;
  logic quote_add = 1'b0;
  logic hex_np = 1'b0;
  logic hex_pending = 1'b0;

  out_item_t escape_run[$];
  out_item_t expected_chars[$];
  dir_row_t  dir_rows[$];

  int n_errors = 0;
  int tx_mode = 0;
  int rx_mode = 0;
  int rx_wait = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;

  backslash_escape_encoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #(TIMEOUT);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_char(logic [CHAR_BITS-1:0] ch);
    out_item_t o;
    o.out_char    = ch;
    o.last_of_run = 1'b0;
    escape_run.push_back(o);
  endfunction

  function automatic void push_hex(logic [31:0] c, int digits);
    logic [3:0] nib;
    push_char(CH_BSLASH);
    push_char(CH_LX);
    for (int k = digits - 1; k >= 0; k--) begin
      nib = 4'((c >> (4 * k)) & 32'd15);
      push_char((nib < 4'd10) ? CHAR_BITS'(CH_ZERO + nib) : CHAR_BITS'(CH_LA + nib - 4'd10));
    end
  endfunction

  function automatic void predict_escape(in_item_t it);
    logic [31:0]          c;
    logic [CHAR_BITS-1:0] sub;
    logic                 is_hex;
    int                   digits;
    out_item_t            tail;
    escape_run.delete();
    c = 32'(it.in_char);
    sub = '0;
    case (it.op)
      OP_START, OP_END: begin
        hex_pending = 1'b0;
        if (quote_add) push_char(quote_dq ? CH_DQUOTE : CH_SQUOTE);
      end
      OP_CHAR: begin
        case (it.in_char)
          CH_BSLASH: sub = CH_BSLASH;
          CH_DQUOTE: if (quote_dq) sub = CH_DQUOTE;
          CH_SQUOTE: if (!quote_dq) sub = CH_SQUOTE;
          CH_NUL:    sub = CH_ZERO;
          CH_LF:     sub = CH_LN;
          CH_CR:     sub = CH_LR;
          CH_BS:     sub = CH_LB;
          CH_FF:     sub = CH_LF_A;
          CH_BEL:    sub = CH_LA;
          CH_VT:     sub = CH_LV;
          default:   sub = '0;
        endcase
        is_hex = (c >= 32'(CH_ZERO) && c <= 32'(CH_NINE)) ||
                 (c >= 32'(CH_LA) && c <= 32'(CH_LF_A)) ||
                 (c >= 32'(CH_UA) && c <= 32'(CH_UF));
        if (sub != '0) begin
          push_char(CH_BSLASH);
          push_char(sub);
          hex_pending = 1'b0;
        end else if (hex_np && (c < 32'(CH_SPACE) || c > 32'(CH_TILDE))) begin
          if (CHAR_BITS > 16 && c[31:16] != 16'd0) digits = 8;
          else if (CHAR_BITS > 8 && c[31:8] != 24'd0) digits = 4;
          else digits = 2;
          push_hex(c, digits);
          hex_pending = 1'b1;
        end else if (hex_pending && is_hex) begin
          // keep the digit from merging into the escape before it
          push_hex(c, 2);
        end else begin
          push_char(it.in_char);
          hex_pending = 1'b0;
        end
      end
      default: ;
    endcase
    if (escape_run.size() > 0) begin
      tail = escape_run.pop_back();
      tail.last_of_run = 1'b1;
      escape_run.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic int draw_wait(int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, MAX_WAIT)) : 0;
      default: return int'($urandom_range(0, MAX_WAIT));
    endcase
  endfunction

  function automatic logic [CHAR_BITS-1:0] rand_char();
    logic [CHAR_BITS-1:0] specials [11];
    specials = '{CH_NUL, CH_BEL, CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR,
                 CH_DQUOTE, CH_SQUOTE, CH_BSLASH};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CHAR_BITS'($urandom_range(32, 126));
      4, 5: begin
        case ($urandom_range(0, 2))
          0: return CHAR_BITS'($urandom_range(CH_ZERO, CH_NINE));
          1: return CHAR_BITS'($urandom_range(CH_LA, CH_LF_A));
          default: return CHAR_BITS'($urandom_range(CH_UA, CH_UF));
        endcase
      end
      6: return specials[$urandom_range(0, 10)];
      7: return CHAR_BITS'($urandom_range(0, 31));
      8: return CHAR_BITS'($urandom_range(127, 255));
      default: return CHAR_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic dir_row_t chr_row(logic [1:0] op, logic [CHAR_BITS-1:0] ch);
    dir_row_t r;
    r.kind   = ROW_ITEM;
    r.idx    = '0;
    r.val    = 1'b0;
    r.item   = '{op: op, in_char: ch};
    r.fixed  = 1'b0;
    r.nfixed = 0;
    r.text   = '0;
    return r;
  endfunction

  function automatic dir_row_t fixed_row(logic [1:0] op, logic [CHAR_BITS-1:0] ch,
                                         int n, logic [31:0] text);
    dir_row_t r;
    r = chr_row(op, ch);
    r.fixed  = 1'b1;
    r.nfixed = n;
    r.text   = text;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic val);
    dir_row_t r;
    r = chr_row(OP_CHAR, '0);
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  // drive one transaction, then queue what it should produce
  task automatic send_item(in_item_t it, logic fixed, int nfixed, logic [31:0] text);
    out_item_t o;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_escape(it);
    if (fixed) begin
      for (int k = 0; k < nfixed; k++) begin
        o.out_char    = text[8 * (nfixed - 1 - k) +: 8];
        o.last_of_run = (k == nfixed - 1);
        expected_chars.push_back(o);
      end
    end else begin
      foreach (escape_run[i]) expected_chars.push_back(escape_run[i]);
    end
  endtask

  task automatic idle_input();
    int gap;
    gap = draw_wait(tx_mode);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic offer(logic [1:0] op, logic [CHAR_BITS-1:0] ch);
    send_item('{op: op, in_char: ch}, 1'b0, 0, '0);
    idle_input();
  endtask

  task automatic drain_output();
    int spin;
    @(negedge clk);
    in_valid <= 1'b0;
    spin = 0;
    while (expected_chars.size() != 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk);
      spin++;
    end
    if (expected_chars.size() != 0) begin
      $error("%0d expected characters never arrived", expected_chars.size());
      n_errors++;
      expected_chars.delete();
    end
    // items without output may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_DOUBLE_QUOTE: quote_dq = val;
      REG_ADD_QUOTES:   quote_add = val;
      REG_ESCAPE_NP:    hex_np = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected transaction: out_char %0h last_of_run %0b",
               out_data.out_char, out_data.last_of_run);
        n_errors++;
      end else begin
        want = expected_chars.pop_front();
        if (out_data.out_char !== want.out_char) begin
          $error("out_char: expected %0h, got %0h", want.out_char, out_data.out_char);
          n_errors++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                 out_data.last_of_run);
          n_errors++;
        end
      end
      rx_wait = draw_wait(rx_mode);
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    int len;
    int sent;
    logic [2:0] setting;
    logic [1:0] op;

    // reset defaults: double quotes, no added quotes, no hex escapes
    dir_rows.push_back(fixed_row(OP_CHAR, CHAR_BITS'(65), 1, "A"));
    dir_rows.push_back(fixed_row(OP_CHAR, CH_NUL, 2, "\\0"));
    dir_rows.push_back(fixed_row(OP_CHAR, CHAR_BITS'(255), 1, 32'hFF));
    dir_rows.push_back(fixed_row(OP_CHAR, CH_BSLASH, 2, "\\\\"));
    dir_rows.push_back(fixed_row(OP_CHAR, CH_DQUOTE, 2, "\\\""));
    dir_rows.push_back(fixed_row(OP_CHAR, CH_SQUOTE, 1, "'"));
    dir_rows.push_back(fixed_row(OP_CHAR, CH_TAB, 1, 32'h09));
    dir_rows.push_back(fixed_row(OP_START, '0, 0, '0));
    dir_rows.push_back(fixed_row(OP_UNUSED, CHAR_BITS'(255), 0, '0));
    dir_rows.push_back(chr_row(OP_CHAR, CH_LF));
    dir_rows.push_back(chr_row(OP_CHAR, CH_CR));
    dir_rows.push_back(chr_row(OP_CHAR, CH_BS));
    dir_rows.push_back(chr_row(OP_CHAR, CH_FF));
    dir_rows.push_back(chr_row(OP_CHAR, CH_BEL));
    dir_rows.push_back(chr_row(OP_CHAR, CH_VT));
    // single quotes, quoting and hex escapes on; the unused index is dropped
    dir_rows.push_back(cfg_row(REG_DOUBLE_QUOTE, 1'b0));
    dir_rows.push_back(cfg_row(REG_ADD_QUOTES, 1'b1));
    dir_rows.push_back(cfg_row(REG_ESCAPE_NP, 1'b1));
    dir_rows.push_back(cfg_row(CFG_IDX_W'(3), 1'b0));
    dir_rows.push_back(fixed_row(OP_START, '0, 1, "'"));
    dir_rows.push_back(fixed_row(OP_CHAR, CH_SQUOTE, 2, "\\'"));
    dir_rows.push_back(fixed_row(OP_CHAR, CH_DQUOTE, 1, "\""));
    dir_rows.push_back(fixed_row(OP_CHAR, CHAR_BITS'(1), 4, "\\x01"));
    dir_rows.push_back(chr_row(OP_CHAR, CH_LA));
    dir_rows.push_back(chr_row(OP_CHAR, CH_UF));
    dir_rows.push_back(chr_row(OP_CHAR, CHAR_BITS'(103)));
    dir_rows.push_back(fixed_row(OP_CHAR, CHAR_BITS'(127), 4, "\\x7f"));
    dir_rows.push_back(chr_row(OP_CHAR, CHAR_BITS'(255)));
    dir_rows.push_back(chr_row(OP_CHAR, CH_TILDE));
    dir_rows.push_back(chr_row(OP_CHAR, CH_TAB));
    dir_rows.push_back(chr_row(OP_CHAR, CH_SPACE));
    dir_rows.push_back(fixed_row(OP_END, '0, 1, "'"));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_mode = 1;
    rx_mode = 1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (expected_chars.size() != 0 || in_valid) drain_output();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].nfixed,
                  dir_rows[i].text);
        idle_input();
      end
    end

    for (int p = 0; p < 8; p++) begin
      drain_output();
      setting = 3'(p);
      tx_mode = (p == 0) ? 0 : int'($urandom_range(0, 2));
      rx_mode = (p == 0) ? 0 : int'($urandom_range(0, 2));
      if (p == 3) begin
        // stall the output long enough to back up the command queue
        tx_mode = 0;
        hold_req = 1'b1;
      end
      write_reg(REG_DOUBLE_QUOTE, setting[0]);
      write_reg(REG_ADD_QUOTES, setting[1]);
      write_reg(REG_ESCAPE_NP, setting[2]);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_W'(3), 1'($urandom_range(0, 1)));

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 6) != 0) begin
          len = $urandom_range(0, 8);
          offer(OP_START, CHAR_BITS'($urandom_range(0, 255)));
          for (int k = 0; k < len; k++) offer(OP_CHAR, rand_char());
          offer(OP_END, CHAR_BITS'($urandom_range(0, 255)));
          sent += len + 2;
        end else begin
          // noise: loose characters, unbalanced markers, unused op
          op = 2'($urandom_range(0, 3));
          offer(op, (op == OP_CHAR) ? rand_char() : CHAR_BITS'($urandom_range(0, 255)));
          if (op != OP_UNUSED) sent++;
        end
      end
    end

    drain_output();
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
